>>> src/btr_pkg.sv
// Shared types, constants and the glyph lookup for the bitmap text renderer.
// Depends on nothing; every other file but btr_ram imports it.
`default_nettype none

package btr_pkg;

	localparam int GLYPH_SLOTS_DEF = 64;
	localparam int OFFSET_BITS_DEF = 26;

	localparam int COORD_W   = 13;
	localparam int ORIGIN_W  = 12;
	localparam int POS_W     = 14;
	localparam int PITCH_W   = 15;
	localparam int CODE_W    = 8;
	localparam int COLOUR_W  = 8;
	localparam int SLOT_W    = 6;
	localparam int FROW_W    = 3;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;

	localparam int NS_BIT     = 0;
	localparam int CODE_LSB   = 1;
	localparam int OX_LSB     = 9;
	localparam int OY_LSB     = 21;
	localparam int RED_LSB    = 33;
	localparam int GREEN_LSB  = 41;
	localparam int BLUE_LSB   = 49;
	localparam int FSLOT_LSB  = 57;
	localparam int FROW_LSB   = 63;
	localparam int FBITS_LSB  = 66;
	localparam int IN_DATA_W  = 80;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 2'd2;

	localparam logic [COORD_W-1:0] WIDTH_RST  = 13'd224;
	localparam logic [COORD_W-1:0] HEIGHT_RST = 13'd256;
	localparam logic [PITCH_W-1:0] PITCH_RST  = 15'd896;

	localparam logic [COORD_W-1:0] COORD_MAX   = 13'd8191;
	localparam logic [POS_W-1:0]   CURSOR_STEP = 14'd8;
	localparam logic [FROW_W-1:0]  GLYPH_LAST  = 3'd7;
	localparam int                 PIXEL_BYTES = 4;

	localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CODE_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CODE_W-1:0] CHAR_DASH  = 8'h2D;
	localparam logic [CODE_W-1:0] CHAR_0     = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_9     = 8'h39;
	localparam logic [CODE_W-1:0] CHAR_LT    = 8'h3C;
	localparam logic [CODE_W-1:0] CHAR_QUERY = 8'h3F;
	localparam logic [CODE_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CODE_W-1:0] CHAR_Z     = 8'h5A;

	localparam logic [SLOT_W-1:0] SLOT_DIGIT = 6'd26;
	localparam logic [SLOT_W-1:0] SLOT_SIGN  = 6'd36;
	localparam logic [SLOT_W-1:0] SLOT_STAR  = 6'd41;
	localparam logic [SLOT_W-1:0] SLOT_DASH  = 6'd42;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} glyph_t;

	typedef struct packed {
		logic load;
		logic pix_step;
		logic row_step;
	} off_ctrl_t;

	function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] c);
		glyph_t g;
		g.valid = 1'b1;
		g.slot  = '0;
		if (c inside {[CHAR_A:CHAR_Z]}) begin
			g.slot = SLOT_W'(c - CHAR_A);
		end else if (c inside {[CHAR_0:CHAR_9]}) begin
			g.slot = SLOT_W'(c - CHAR_0) + SLOT_DIGIT;
		end else if (c inside {[CHAR_LT:CHAR_QUERY]}) begin
			g.slot = SLOT_W'(c - CHAR_LT) + SLOT_SIGN;
		end else if (c == CHAR_STAR) begin
			g.slot = SLOT_STAR;
		end else if (c == CHAR_DASH) begin
			g.slot = SLOT_DASH;
		end else begin
			g.valid = 1'b0;
		end
		return g;
	endfunction

endpackage

`default_nettype wire

>>> src/btr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the font store of the renderer.
`default_nettype none

module btr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/btr_offset.sv
// Frame buffer offset generator: bit-serial row times pitch product, then row and pixel steps.
// Depends on btr_pkg.
`default_nettype none

module btr_offset #(
	parameter int OFFSET_BITS = btr_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire btr_pkg::off_ctrl_t           ctrl,
	input  wire logic [btr_pkg::POS_W-1:0]    px,
	input  wire logic [btr_pkg::POS_W-1:0]    py,
	input  wire logic [btr_pkg::PITCH_W-1:0]  pitch,
	output logic                              busy,
	output logic      [OFFSET_BITS-1:0]       offset
);

	import btr_pkg::*;

	localparam int CNT_W = $clog2(PITCH_W);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [OFFSET_BITS-1:0] base_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] mcand_q;
	logic [PITCH_W-1:0]     mplier_q;
	logic [OFFSET_BITS-1:0] base_sum;
	logic [OFFSET_BITS-1:0] row_next;
	logic                   mul_last;

	assign base_sum = base_q + (mplier_q[0] ? mcand_q : '0);
	assign row_next = base_q + OFFSET_BITS'(pitch);
	assign mul_last = (cnt_q == CNT_W'(PITCH_W - 1));
	assign busy     = busy_q;
	assign offset   = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (mul_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			base_q   <= OFFSET_BITS'({px, 2'b00});
			mcand_q  <= OFFSET_BITS'(py);
			mplier_q <= pitch;
		end else if (busy_q) begin
			base_q   <= base_sum;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			if (mul_last) begin
				off_q <= base_sum;
			end
		end else if (ctrl.row_step) begin
			base_q <= row_next;
			off_q  <= row_next;
		end else if (ctrl.pix_step) begin
			off_q <= off_q + OFFSET_BITS'(PIXEL_BYTES);
		end
	end

endmodule

`default_nettype wire

>>> src/bitmap_text_renderer_core.sv
// Bitmap text renderer top level: input decode, cursor control, glyph bit shifter and result beat.
// Depends on btr_pkg, btr_ram and btr_offset.
//
// Each input beat carries one character or one font row. A font row is written when its beat is taken.
// A glyph character gives 64 pixel beats, one per cycle while the sink takes them, after
// a set-up through the cursor update, the bit-serial row-by-pitch multiply in btr_offset
// and the load of the first font row. Space, carriage return, line feed and unknown codes
// give one beat after the cursor update, and a character met while halted gives one beat
// without a cursor update. The next beat is taken once the current character has handed
// its final result to the output register. The font store has no reset and a glyph must
// be loaded before it is drawn.
`default_nettype none

module bitmap_text_renderer_core #(
	parameter int GLYPH_SLOTS = btr_pkg::GLYPH_SLOTS_DEF,
	parameter int OFFSET_BITS = btr_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// new_string, char_code, origin_x, origin_y, red, green, blue, font_slot, font_row,
	// font_bits, zero padding
	input  wire logic [btr_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pixel_offset, out_red, out_green, out_blue, zero padding
	output logic [((OFFSET_BITS + 3 * btr_pkg::COLOUR_W + 7) / 8) * 8 - 1:0] m_tdata,
	// write_enable, out_of_space
	output logic [1:0]                             m_tuser,
	// last_of_char
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [btr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [btr_pkg::CFG_W-1:0]         cfg_data
);

	import btr_pkg::*;

	localparam int SW    = $clog2(GLYPH_SLOTS);
	localparam int DEPTH = GLYPH_SLOTS * 8;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_WRAP = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_LD   = 3'd4;
	localparam logic [2:0] ST_PIX  = 3'd5;
	localparam logic [2:0] ST_ONE  = 3'd6;

	logic [2:0]             state_q;
	logic [COORD_W-1:0]     col_q;
	logic [COORD_W-1:0]     row_q;
	logic                   halt_q;
	logic                   oos_q;
	logic [FROW_W-1:0]      glyph_row_q;
	logic [FROW_W-1:0]      pix_col_q;
	logic [COORD_W-1:0]     width_q;
	logic [COORD_W-1:0]     height_q;
	logic [PITCH_W-1:0]     pitch_q;

	logic [CODE_W-1:0]      code_q;
	logic [ORIGIN_W-1:0]    ox_q;
	logic [ORIGIN_W-1:0]    oy_q;
	logic [COLOUR_W-1:0]    red_q;
	logic [COLOUR_W-1:0]    green_q;
	logic [COLOUR_W-1:0]    blue_q;
	logic [POS_W-1:0]       px_q;
	logic [POS_W-1:0]       py_q;
	logic [POS_W-1:0]       nx_q;
	logic [POS_W-1:0]       ny_q;
	logic [7:0]             bits_q;

	logic                   out_valid_q;
	logic                   out_we_q;
	logic [OFFSET_BITS-1:0] out_off_q;
	logic [COLOUR_W-1:0]    out_red_q;
	logic [COLOUR_W-1:0]    out_green_q;
	logic [COLOUR_W-1:0]    out_blue_q;
	logic                   out_last_q;
	logic                   out_oos_q;

	logic                   in_acc;
	logic                   in_new_string;
	logic [SLOT_W-1:0]      in_font_slot;
	logic [FROW_W-1:0]      in_font_row;
	logic [7:0]             in_font_bits;
	logic                   font_we;
	glyph_t                 glyph;
	logic                   glyph_ok;
	logic                   out_free;
	logic                   emit;
	logic                   row_end;
	logic                   rd_en;
	logic [FROW_W-1:0]      rd_row;
	logic [7:0]             ram_rdata;
	logic [POS_W-1:0]       x_sum;
	logic                   wrap;
	logic [POS_W-1:0]       x2;
	logic [POS_W-1:0]       y2;
	logic [POS_W-1:0]       y_sum;
	logic                   halt_new;
	logic                   is_cr;
	logic                   is_lf;
	off_ctrl_t              off_ctrl;
	logic                   off_busy;
	logic [OFFSET_BITS-1:0] off_value;

	assign s_tready      = (state_q == ST_IDLE);
	assign in_acc        = s_tvalid && s_tready;
	assign in_new_string = s_tdata[NS_BIT];
	assign in_font_slot  = s_tdata[FSLOT_LSB +: SLOT_W];
	assign in_font_row   = s_tdata[FROW_LSB +: FROW_W];
	assign in_font_bits  = s_tdata[FBITS_LSB +: 8];
	assign font_we       = in_acc && s_tuser && (in_font_slot < GLYPH_SLOTS);

	assign glyph    = glyph_lookup(code_q);
	assign glyph_ok = glyph.valid && (SW'(glyph.slot) < GLYPH_SLOTS);
	assign is_cr    = (code_q == CHAR_CR);
	assign is_lf    = (code_q == CHAR_LF);

	assign out_free = !out_valid_q || m_tready;
	assign emit     = out_free && ((state_q == ST_PIX) || (state_q == ST_ONE));
	assign row_end  = (pix_col_q == GLYPH_LAST);

	assign x_sum    = nx_q + POS_W'(ox_q);
	assign wrap     = (x_sum >= POS_W'(width_q));
	assign x2       = wrap ? '0 : nx_q;
	assign y2       = wrap ? (ny_q + CURSOR_STEP) : ny_q;
	assign y_sum    = y2 + POS_W'(oy_q);
	assign halt_new = (y_sum >= POS_W'(height_q));

	always_comb begin
		rd_en  = 1'b0;
		rd_row = '0;
		case (state_q)
			ST_WRAP: begin
				rd_en = glyph_ok;
			end
			ST_LD: begin
				rd_en  = 1'b1;
				rd_row = FROW_W'(1);
			end
			ST_PIX: begin
				rd_en  = emit && row_end && (glyph_row_q < GLYPH_LAST - FROW_W'(1));
				rd_row = glyph_row_q + FROW_W'(2);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		off_ctrl.load     = (state_q == ST_WRAP) && glyph_ok;
		off_ctrl.pix_step = (state_q == ST_PIX) && emit && !row_end;
		off_ctrl.row_step = (state_q == ST_PIX) && emit && row_end;
	end

	btr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr ({SW'(in_font_slot), in_font_row}),
		.wdata (in_font_bits),
		.re    (rd_en),
		.raddr ({SW'(glyph.slot), rd_row}),
		.rdata (ram_rdata)
	);

	btr_offset #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (off_ctrl),
		.px     (px_q),
		.py     (py_q),
		.pitch  (pitch_q),
		.busy   (off_busy),
		.offset (off_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			pitch_q  <= PITCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data[COORD_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= cfg_data[COORD_W-1:0];
				REG_LINE_PITCH:    pitch_q  <= cfg_data[PITCH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			halt_q      <= 1'b0;
			oos_q       <= 1'b0;
			glyph_row_q <= '0;
			pix_col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !s_tuser) begin
						if (in_new_string) begin
							col_q  <= '0;
							row_q  <= '0;
							halt_q <= 1'b0;
						end
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (halt_q) begin
						oos_q   <= 1'b1;
						state_q <= ST_ONE;
					end else begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					col_q   <= (x2 > POS_W'(COORD_MAX)) ? COORD_MAX : x2[COORD_W-1:0];
					row_q   <= (y2 > POS_W'(COORD_MAX)) ? COORD_MAX : y2[COORD_W-1:0];
					halt_q  <= halt_new;
					oos_q   <= halt_new;
					state_q <= glyph_ok ? ST_MUL : ST_ONE;
				end
				ST_MUL: begin
					if (!off_busy) begin
						state_q <= ST_LD;
					end
				end
				ST_LD: begin
					glyph_row_q <= '0;
					pix_col_q   <= '0;
					state_q     <= ST_PIX;
				end
				ST_PIX: begin
					if (emit) begin
						pix_col_q <= pix_col_q + FROW_W'(1);
						if (row_end) begin
							glyph_row_q <= glyph_row_q + FROW_W'(1);
							if (glyph_row_q == GLYPH_LAST) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_ONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q  <= s_tdata[CODE_LSB +: CODE_W];
			ox_q    <= s_tdata[OX_LSB +: ORIGIN_W];
			oy_q    <= s_tdata[OY_LSB +: ORIGIN_W];
			red_q   <= s_tdata[RED_LSB +: COLOUR_W];
			green_q <= s_tdata[GREEN_LSB +: COLOUR_W];
			blue_q  <= s_tdata[BLUE_LSB +: COLOUR_W];
		end
		if (state_q == ST_CALC) begin
			px_q <= POS_W'(col_q) + POS_W'(ox_q);
			py_q <= POS_W'(row_q) + POS_W'(oy_q);
			nx_q <= (is_cr || is_lf) ? '0 : (POS_W'(col_q) + CURSOR_STEP);
			ny_q <= is_lf ? (POS_W'(row_q) + CURSOR_STEP) : POS_W'(row_q);
		end
		if (state_q == ST_LD) begin
			bits_q <= ram_rdata;
		end else if ((state_q == ST_PIX) && emit) begin
			bits_q <= row_end ? ram_rdata : (bits_q << 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_we_q    <= (state_q == ST_PIX);
			out_off_q   <= (state_q == ST_PIX) ? off_value : '0;
			out_red_q   <= ((state_q == ST_PIX) && bits_q[7]) ? red_q : '0;
			out_green_q <= ((state_q == ST_PIX) && bits_q[7]) ? green_q : '0;
			out_blue_q  <= ((state_q == ST_PIX) && bits_q[7]) ? blue_q : '0;
			out_last_q  <= (state_q == ST_ONE) || (row_end && (glyph_row_q == GLYPH_LAST));
			out_oos_q   <= oos_q;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[OFFSET_BITS-1:0]                      = out_off_q;
		m_tdata[OFFSET_BITS +: COLOUR_W]              = out_red_q;
		m_tdata[OFFSET_BITS + COLOUR_W +: COLOUR_W]   = out_green_q;
		m_tdata[OFFSET_BITS + 2*COLOUR_W +: COLOUR_W] = out_blue_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_oos_q, out_we_q};
	assign m_tlast  = out_last_q;

	a_pix_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX) |-> !off_busy)
		else $error("Pixel beats started before the offset product was ready.");

	a_blank_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("A beat without a pixel write was not the last of its character.");

	a_halt_from_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halt_q) |-> ($past(state_q) == ST_WRAP))
		else $error("Halt flag set outside the cursor update.");

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((glyph_row_q == '0) && (pix_col_q == '0)))
		else $error("Glyph counters not back at zero when idle.");

endmodule

`default_nettype wire

>>> tb/btr_tb_pkg.sv
`timescale 1ns / 100ps
// Testbench-side constants and the result beat type for the bitmap text renderer.
// Depends on btr_pkg; the checker and the testbench top import it.

package btr_tb_pkg;

	import btr_pkg::*;

	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_FONT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CODE_W-1:0] CHAR_TOP   = 8'hFF;

	localparam int OUT_DATA_W    = ((OFFSET_BITS_DEF + 3 * COLOUR_W + 7) / 8) * 8;
	localparam int OUT_RED_LSB   = OFFSET_BITS_DEF;
	localparam int OUT_GREEN_LSB = OUT_RED_LSB + COLOUR_W;
	localparam int OUT_BLUE_LSB  = OUT_GREEN_LSB + COLOUR_W;
	localparam int TUSER_WE      = 0;
	localparam int TUSER_OOS     = 1;

	typedef struct packed {
		logic                       we;
		logic [OFFSET_BITS_DEF-1:0] off;
		logic [COLOUR_W-1:0]        r;
		logic [COLOUR_W-1:0]        g;
		logic [COLOUR_W-1:0]        b;
		logic                       last;
		logic                       oos;
	} pixel_beat_t;

endpackage

>>> tb/btr_render_checker.sv
`timescale 1ns / 100ps
// Checker for the bitmap text renderer: follows the input, result and register channels,
// predicts the pixel beats of every character and compares them. Depends on btr_tb_pkg.

module btr_render_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic [btr_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                             s_tuser,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic [btr_tb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic [1:0]                       m_tuser,
	input  wire logic                             m_tlast,
	input  wire logic                             cfg_we,
	input  wire logic [btr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [btr_pkg::CFG_W-1:0]        cfg_data,
	output int                                    errors,
	output int                                    pending
);

	import btr_pkg::*;
	import btr_tb_pkg::*;

	pixel_beat_t pixel_due[$];
	pixel_beat_t want;
	logic [7:0]  font_mem [0:GLYPH_SLOTS_DEF*8-1];
	int unsigned col, row, scr_w, scr_h, pitch;
	logic        halted;
	int          beat_no;

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		errors++;
		$display("mismatch at result beat %0d: %s, got %0h, wanted %0h",
			beat_no, what, got, exp_val);
	endtask

	function automatic int glyph_of(input logic [CODE_W-1:0] c);
		if (c >= CHAR_A && c <= CHAR_Z) return int'(c - CHAR_A);
		if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0) + int'(SLOT_DIGIT);
		if (c >= CHAR_LT && c <= CHAR_QUERY) return int'(c - CHAR_LT) + int'(SLOT_SIGN);
		if (c == CHAR_STAR) return int'(SLOT_STAR);
		if (c == CHAR_DASH) return int'(SLOT_DASH);
		return -1;
	endfunction

	task automatic render_char(input logic [IN_DATA_W-1:0] d);
		pixel_beat_t         glyph_px [64];
		pixel_beat_t         pb;
		logic [CODE_W-1:0]   code;
		logic [COLOUR_W-1:0] r, g, b;
		logic [7:0]          bits;
		logic [63:0]         off;
		logic                lit;
		int unsigned         ox, oy, x, y;
		int                  slot, n, i, j;
		code = d[CODE_LSB +: CODE_W];
		ox = d[OX_LSB +: ORIGIN_W];
		oy = d[OY_LSB +: ORIGIN_W];
		r = d[RED_LSB +: COLOUR_W];
		g = d[GREEN_LSB +: COLOUR_W];
		b = d[BLUE_LSB +: COLOUR_W];
		n = 0;
		if (d[NS_BIT]) begin
			col = 0;
			row = 0;
			halted = 1'b0;
		end
		if (halted) begin
			pb = '0;
			pb.last = 1'b1;
			pb.oos = 1'b1;
			pixel_due.push_back(pb);
		end else begin
			x = col;
			y = row;
			slot = glyph_of(code);
			if (slot >= 0 && slot < GLYPH_SLOTS_DEF) begin
				for (i = 0; i < 8; i++) begin
					bits = font_mem[slot * 8 + i];
					for (j = 0; j < 8; j++) begin
						off = 64'(y + oy + i) * 64'(pitch)
							+ 64'(x + ox + j) * 64'(PIXEL_BYTES);
						lit = bits[7 - j];
						pb.we = 1'b1;
						pb.off = off[OFFSET_BITS_DEF-1:0];
						pb.r = lit ? r : '0;
						pb.g = lit ? g : '0;
						pb.b = lit ? b : '0;
						pb.last = 1'b0;
						pb.oos = 1'b0;
						glyph_px[n] = pb;
						n++;
					end
				end
			end
			if (code == CHAR_CR) begin
				x = 0;
			end else if (code == CHAR_LF) begin
				x = 0;
				y += CURSOR_STEP;
			end else begin
				x += CURSOR_STEP;
			end
			if (x + ox >= scr_w) begin
				x = 0;
				y += CURSOR_STEP;
			end
			if (y + oy >= scr_h) halted = 1'b1;
			col = (x > COORD_MAX) ? COORD_MAX : x;
			row = (y > COORD_MAX) ? COORD_MAX : y;
			if (n == 0) begin
				pb = '0;
				pb.last = 1'b1;
				pb.oos = halted;
				pixel_due.push_back(pb);
			end else begin
				for (i = 0; i < n; i++) begin
					pb = glyph_px[i];
					pb.oos = halted;
					pb.last = (i == n - 1);
					pixel_due.push_back(pb);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_due.delete();
			col = 0;
			row = 0;
			halted = 1'b0;
			scr_w = WIDTH_RST;
			scr_h = HEIGHT_RST;
			pitch = PITCH_RST;
			errors = 0;
			pending = 0;
			beat_no = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_due.size() == 0) begin
					note_mismatch("result beat with nothing pending", m_tdata, '0);
				end else begin
					want = pixel_due.pop_front();
					if (m_tuser[TUSER_WE] !== want.we)
						note_mismatch("write_enable", m_tuser[TUSER_WE], want.we);
					if (m_tdata[OFFSET_BITS_DEF-1:0] !== want.off)
						note_mismatch("pixel_offset", m_tdata[OFFSET_BITS_DEF-1:0], want.off);
					if (m_tdata[OUT_RED_LSB +: COLOUR_W] !== want.r)
						note_mismatch("out_red", m_tdata[OUT_RED_LSB +: COLOUR_W], want.r);
					if (m_tdata[OUT_GREEN_LSB +: COLOUR_W] !== want.g)
						note_mismatch("out_green", m_tdata[OUT_GREEN_LSB +: COLOUR_W], want.g);
					if (m_tdata[OUT_BLUE_LSB +: COLOUR_W] !== want.b)
						note_mismatch("out_blue", m_tdata[OUT_BLUE_LSB +: COLOUR_W], want.b);
					if (m_tlast !== want.last)
						note_mismatch("last_of_char", m_tlast, want.last);
					if (m_tuser[TUSER_OOS] !== want.oos)
						note_mismatch("out_of_space", m_tuser[TUSER_OOS], want.oos);
				end
				beat_no++;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_FONT) begin
					font_mem[{s_tdata[FSLOT_LSB +: SLOT_W], s_tdata[FROW_LSB +: FROW_W]}]
						= s_tdata[FBITS_LSB +: 8];
				end else begin
					render_char(s_tdata);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: begin
						scr_w = cfg_data[COORD_W-1:0];
					end
					REG_SCREEN_HEIGHT: begin
						scr_h = cfg_data[COORD_W-1:0];
					end
					REG_LINE_PITCH: begin
						pitch = cfg_data[PITCH_W-1:0];
					end
					default: begin
					end
				endcase
			end
			pending = pixel_due.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the bitmap text renderer: loads a font, draws directed and random text
// under several screen settings with random idling, and reports the checker's verdict.

module tb_top;

	import btr_pkg::*;
	import btr_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES  = 600;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	int                     errors;
	int                     pending;

	logic source_lively;
	logic sink_lively;
	logic sink_hold;
	int   cur_w, cur_h;
	int   cycle_count;

	bitmap_text_renderer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	btr_render_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_req(input logic nstr,
			input logic [CODE_W-1:0] code, input logic [ORIGIN_W-1:0] ox,
			input logic [ORIGIN_W-1:0] oy, input logic [COLOUR_W-1:0] r,
			input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b,
			input logic [SLOT_W-1:0] slot, input logic [FROW_W-1:0] frow,
			input logic [7:0] fbits);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[NS_BIT] = nstr;
		d[CODE_LSB +: CODE_W] = code;
		d[OX_LSB +: ORIGIN_W] = ox;
		d[OY_LSB +: ORIGIN_W] = oy;
		d[RED_LSB +: COLOUR_W] = r;
		d[GREEN_LSB +: COLOUR_W] = g;
		d[BLUE_LSB +: COLOUR_W] = b;
		d[FSLOT_LSB +: SLOT_W] = slot;
		d[FROW_LSB +: FROW_W] = frow;
		d[FBITS_LSB +: 8] = fbits;
		return d;
	endfunction

	// Forty-two codes with a glyph; slot forty has none.
	function automatic logic [CODE_W-1:0] glyph_code(input int k);
		if (k < 26) return CHAR_A + CODE_W'(k);
		if (k < 36) return CHAR_0 + CODE_W'(k - 26);
		if (k < 40) return CHAR_LT + CODE_W'(k - 36);
		if (k == 40) return CHAR_STAR;
		return CHAR_DASH;
	endfunction

	// Called and left at a falling edge.
	task automatic send_beat(input logic req, input logic [IN_DATA_W-1:0] d);
		int gap;
		gap = source_lively ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_char(input logic nstr, input logic [CODE_W-1:0] code,
			input int ox, input int oy, input int r, input int g, input int b);
		send_beat(REQ_DRAW, pack_req(nstr, code, ORIGIN_W'(ox), ORIGIN_W'(oy),
			COLOUR_W'(r), COLOUR_W'(g), COLOUR_W'(b), SLOT_W'($urandom_range(0, 63)),
			FROW_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
	endtask

	task automatic send_font(input int slot, input int frow, input int fbits);
		send_beat(REQ_FONT, pack_req(1'($urandom_range(0, 1)),
			CODE_W'($urandom_range(0, 255)), ORIGIN_W'($urandom_range(0, 4095)),
			ORIGIN_W'($urandom_range(0, 4095)), COLOUR_W'($urandom_range(0, 255)),
			COLOUR_W'($urandom_range(0, 255)), COLOUR_W'($urandom_range(0, 255)),
			SLOT_W'(slot), FROW_W'(frow), 8'(fbits)));
	endtask

	task automatic set_screen(input int w, input int h, input int p);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= CFG_W'(w);
		@(negedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(negedge clk);
		cfg_index <= REG_LINE_PITCH;
		cfg_data <= CFG_W'(p);
		@(negedge clk);
		cfg_index <= REG_NONE;
		cfg_data <= CFG_W'($urandom_range(0, 32767));
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_w = w;
		cur_h = h;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Strings open with new_string and keep one origin; a few start without it,
	// restart midway, or have font rows rewritten between characters.
	task automatic run_strings(input int n_items);
		int               sent, len, k, pick, ox, oy;
		logic             nstr;
		logic [CODE_W-1:0] code;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 24);
			ox = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(0, cur_w - 1);
			oy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(0, cur_h - 1);
			for (k = 0; k < len && sent < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					send_font($urandom_range(0, 63), $urandom_range(0, 7),
						$urandom_range(0, 255));
				end else begin
					if (pick < 66) code = glyph_code($urandom_range(0, 41));
					else if (pick < 74) code = CHAR_SPACE;
					else if (pick < 80) code = CHAR_CR;
					else if (pick < 86) code = CHAR_LF;
					else code = CODE_W'($urandom_range(0, 255));
					nstr = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
					send_char(nstr, code, ox, oy, $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				end
				sent++;
			end
		end
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (sink_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				sink_hold = 1'b0;
			end
			stall = sink_lively ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int slot, frow;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_DRAW;
		cfg_we = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		source_lively = 1'b0;
		sink_lively = 1'b1;
		sink_hold = 1'b0;
		cur_w = WIDTH_RST;
		cur_h = HEIGHT_RST;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (slot = 0; slot <= SLOT_DASH; slot++) begin
			for (frow = 0; frow < 8; frow++) send_font(slot, frow, $urandom_range(0, 255));
		end

		source_lively = 1'b1;
		send_font(0, 0, 8'hFF);
		send_font(0, 7, 8'h00);
		send_font(0, 3, 8'h81);
		send_font(63, 7, 8'hFF);
		send_char(1'b1, CHAR_A, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_Z, 0, 0, 8'h00, 8'hFF, 8'h00);
		send_char(1'b0, CHAR_0, 0, 0, 8'h12, 8'h34, 8'h56);
		send_char(1'b0, CHAR_9, 0, 0, 8'hFF, 8'h00, 8'hFF);
		send_char(1'b0, CHAR_LT, 0, 0, 8'hA5, 8'h5A, 8'hC3);
		send_char(1'b0, CHAR_QUERY, 0, 0, 8'h01, 8'h80, 8'h7F);
		send_char(1'b0, CHAR_STAR, 0, 0, 8'hFE, 8'hEF, 8'h10);
		send_char(1'b0, CHAR_DASH, 0, 0, 8'h3C, 8'hC3, 8'h99);
		send_char(1'b0, CHAR_SPACE, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_CR, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_LF, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_NUL, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_TOP, 0, 0, 8'hFF, 8'hFF, 8'hFF);
		// Drawn below the screen first, then every further character is refused.
		send_char(1'b1, CHAR_Z - 8'd13, 4095, 4095, 8'h00, 8'h00, 8'h00);
		send_char(1'b0, CHAR_A + 8'd1, 4095, 4095, 8'hFF, 8'hFF, 8'hFF);
		send_char(1'b0, CHAR_LF, 4095, 4095, 8'hFF, 8'hFF, 8'hFF);
		// Drawn on the last text line, then wraps off the right edge below the screen and halts.
		send_char(1'b1, CHAR_A + 8'd2, 216, 248, 8'h80, 8'h40, 8'h20);
		send_char(1'b1, CHAR_CR, 0, 0, 8'h00, 8'h00, 8'h00);
		send_char(1'b1, CHAR_DASH, 100, 0, 8'hFF, 8'hFF, 8'hFF);
		settle();

		set_screen(4096, 4096, 16384);
		run_strings(40);
		settle();

		source_lively = 1'b0;
		sink_lively = 1'b0;
		set_screen(1, 1, 0);
		run_strings(40);
		settle();

		// Sink stalls for a long stretch while beats keep arriving back to back.
		sink_lively = 1'b1;
		set_screen(64, 40, 256);
		sink_hold = 1'b1;
		run_strings(50);
		settle();

		source_lively = 1'b1;
		set_screen($urandom_range(8, 640), $urandom_range(8, 480), $urandom_range(0, 16384));
		run_strings(60);
		settle();

		set_screen(4096, 24, $urandom_range(0, 16384));
		run_strings(40);
		settle();

		set_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(0, 16384));
		run_strings(70);
		settle();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
src/btr_pkg.sv
src/btr_ram.sv
src/btr_offset.sv
src/bitmap_text_renderer_core.sv
tb/btr_tb_pkg.sv
tb/btr_render_checker.sv
tb/tb_top.sv
